FILE: hw/rtl/byte_vm_instruction_execute_top_macros.svh
// Assertion macros shared by the byte VM RTL.
// Needs a clock and an active-high reset in scope at the point of use.
`ifndef BYTE_VM_INSTRUCTION_EXECUTE_TOP_MACROS_SVH
`define BYTE_VM_INSTRUCTION_EXECUTE_TOP_MACROS_SVH

// same-cycle implication
`define BVM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvm assertion failed");

// next-cycle implication
`define BVM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvm assertion failed");

`endif

FILE: hw/rtl/bvm_pkg.sv
`timescale 1ns / 1ps
// Package for the byte VM instruction executor: opcodes and default sizes.
// No dependencies.
package bvm_pkg;

  localparam int REG_COUNT_DEF = 16;
  localparam int PC_BITS_DEF   = 16;
  localparam int NIBBLE_VALUES = 16;
  localparam int RSP_PC_W      = 16;

  typedef enum logic [7:0] {
    OP_INC  = 8'h01,
    OP_DEC  = 8'h02,
    OP_MOV  = 8'h03,
    OP_MOVC = 8'h04,
    OP_LSL  = 8'h05,
    OP_LSR  = 8'h06,
    OP_JMP  = 8'h07,
    OP_JZ   = 8'h08,
    OP_JNZ  = 8'h09,
    OP_JFE  = 8'h0A,
    OP_RET  = 8'h0B,
    OP_ADD  = 8'h0C,
    OP_SUB  = 8'h0D,
    OP_XOR  = 8'h0E,
    OP_OR   = 8'h0F,
    OP_IN   = 8'h10,
    OP_OUT  = 8'h11,
    OP_CMPZ = 8'h12
  } opcode_t;

endpackage

FILE: hw/rtl/bvm_regfile.sv
`timescale 1ns / 1ps
// Byte VM register file: one write port, two registered read ports with
// write-to-read forwarding. Entries read as zero until first written after reset.
module bvm_regfile #(
  parameter int REG_COUNT = bvm_pkg::REG_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         re,
  input  logic [$clog2(REG_COUNT)-1:0] ra,
  input  logic [$clog2(REG_COUNT)-1:0] rb,
  output logic [7:0]                   ra_data,
  output logic [7:0]                   rb_data,
  input  logic                         we,
  input  logic [$clog2(REG_COUNT)-1:0] waddr,
  input  logic [7:0]                   wdata
);

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] filled;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (we) begin
      filled[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && waddr == ra) begin
        ra_data <= wdata;
      end else if (filled[ra]) begin
        ra_data <= mem[ra];
      end else begin
        ra_data <= '0;
      end
      if (we && waddr == rb) begin
        rb_data <= wdata;
      end else if (filled[rb]) begin
        rb_data <= mem[rb];
      end else begin
        rb_data <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/byte_vm_instruction_execute_top.sv
`timescale 1ns / 1ps
// Byte VM instruction executor, top level.
// Uses bvm_pkg, bvm_regfile and byte_vm_instruction_execute_top_macros.svh.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one two-byte instruction
//   (req_type, operand) plus the current input-stream byte and end marker.
//   Response channel (rsp_valid/rsp_ready) returns one result per request:
//   next_pc, out_valid/out_byte for OUT, in_taken for IN, halted, illegal.
//   An accepted request goes into the operand-fetch register, then is
//   executed into the response register. Throughput: one instruction per
//   cycle while rsp_ready is high; the register file read happens as
//   the request is captured and forwards the write of the instruction
//   executing in the same cycle, so back-to-back dependencies need no bubble.
//   When rsp_ready is low the response register holds; one more request is
//   taken into the fetch register, then req_ready drops until space frees.
//   Reset clears registers to zero, pc to zero and all flags. After RET or an
//   unknown opcode every later request returns next_pc = pc with halted set.
module byte_vm_instruction_execute_top #(
  parameter int REG_COUNT = bvm_pkg::REG_COUNT_DEF,
  parameter int PC_BITS   = bvm_pkg::PC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [7:0]                    req_type,
  input  logic [7:0]                    operand,
  input  logic [7:0]                    in_byte,
  input  logic                          in_at_end,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [bvm_pkg::RSP_PC_W-1:0]  next_pc,
  output logic                          out_valid,
  output logic [7:0]                    out_byte,
  output logic                          in_taken,
  output logic                          halted,
  output logic                          illegal
);

  import bvm_pkg::*;

  `include "byte_vm_instruction_execute_top_macros.svh"

  localparam int IdxW = $clog2(REG_COUNT);
  localparam int PcW  = (PC_BITS > RSP_PC_W) ? PC_BITS : RSP_PC_W;

  // nibble -> register index (nibble modulo REG_COUNT)
  logic [IdxW-1:0] idx_map [NIBBLE_VALUES];
  for (genvar g = 0; g < NIBBLE_VALUES; g++) begin : g_idx
    assign idx_map[g] = IdxW'(g % REG_COUNT);
  end

  // fetch stage
  logic       held_valid;
  logic [7:0] held_type;
  logic [7:0] held_operand;
  logic [7:0] held_in_byte;
  logic       held_at_end;
  logic [7:0] rd_val;
  logic [7:0] rs_val;

  // architectural state
  logic [PC_BITS-1:0] pc;
  logic               zero_flag;
  logic               end_flag;
  logic               stopped;

  logic               req_fire;
  logic               adv;
  logic [IdxW-1:0]    held_rd;

  logic [PC_BITS-1:0] pc_next;
  logic [PcW-1:0]     pc_wide;
  logic               zero_flag_next;
  logic               end_flag_next;
  logic               stopped_next;
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  logic [7:0]         wr_data;
  logic               rf_we;
  logic               ov_next;
  logic [7:0]         ob_next;
  logic               it_next;
  logic               ill_next;
  logic [PC_BITS-1:0] offset;

  assign req_fire  = req_valid && req_ready;
  assign adv       = held_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !held_valid || adv;
  assign held_rd   = idx_map[held_operand[3:0]];
  assign offset    = PC_BITS'($signed(held_operand));
  assign rf_we     = adv && wr_en;
  assign pc_wide   = PcW'(pc_next);

  bvm_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .re     (req_fire),
    .ra     (idx_map[operand[3:0]]),
    .rb     (idx_map[operand[7:4]]),
    .ra_data(rd_val),
    .rb_data(rs_val),
    .we     (rf_we),
    .waddr  (wr_addr),
    .wdata  (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_fire) begin
      held_valid <= 1'b1;
    end else if (adv) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      held_type    <= req_type;
      held_operand <= operand;
      held_in_byte <= in_byte;
      held_at_end  <= in_at_end;
    end
  end

  // execute
  always_comb begin
    pc_next        = pc + PC_BITS'(2);
    zero_flag_next = zero_flag;
    end_flag_next  = end_flag;
    stopped_next   = stopped;
    wr_en          = 1'b0;
    wr_addr        = held_rd;
    wr_data        = '0;
    ov_next        = 1'b0;
    ob_next        = '0;
    it_next        = 1'b0;
    ill_next       = 1'b0;
    if (stopped) begin
      pc_next = pc;
    end else begin
      unique case (held_type)
        OP_INC: begin
          wr_en   = 1'b1;
          wr_data = rd_val + 8'd1;
        end
        OP_DEC: begin
          wr_en   = 1'b1;
          wr_data = rd_val - 8'd1;
        end
        OP_MOV: begin
          wr_en   = 1'b1;
          wr_data = rs_val;
        end
        OP_MOVC: begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = held_operand;
        end
        OP_LSL: begin
          wr_en   = 1'b1;
          wr_data = {rd_val[6:0], 1'b0};
        end
        OP_LSR: begin
          wr_en   = 1'b1;
          wr_data = {1'b0, rd_val[7:1]};
        end
        OP_JMP: pc_next = pc + offset;
        OP_JZ: begin
          if (!zero_flag) pc_next = pc + offset;
        end
        OP_JNZ: begin
          if (zero_flag) pc_next = pc + offset;
        end
        OP_JFE: begin
          if (end_flag) pc_next = pc + offset;
        end
        OP_RET: begin
          stopped_next = 1'b1;
          pc_next      = pc;
        end
        OP_ADD: begin
          wr_en   = 1'b1;
          wr_data = rd_val + rs_val;
        end
        OP_SUB: begin
          wr_en   = 1'b1;
          wr_data = rd_val - rs_val;
        end
        OP_XOR: begin
          wr_en   = 1'b1;
          wr_data = rd_val ^ rs_val;
        end
        OP_OR: begin
          wr_en   = 1'b1;
          wr_data = rd_val | rs_val;
        end
        OP_IN: begin
          if (held_at_end) begin
            end_flag_next = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_data = held_in_byte;
            it_next = 1'b1;
          end
        end
        OP_OUT: begin
          ov_next = 1'b1;
          ob_next = rd_val;
        end
        OP_CMPZ: begin
          if (rd_val == 8'd0) zero_flag_next = 1'b1;
        end
        default: begin
          stopped_next = 1'b1;
          ill_next     = 1'b1;
          pc_next      = pc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      zero_flag <= 1'b0;
      end_flag  <= 1'b0;
      stopped   <= 1'b0;
    end else if (adv) begin
      pc        <= pc_next;
      zero_flag <= zero_flag_next;
      end_flag  <= end_flag_next;
      stopped   <= stopped_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      next_pc   <= pc_wide[RSP_PC_W-1:0];
      out_valid <= ov_next;
      out_byte  <= ob_next;
      in_taken  <= it_next;
      halted    <= stopped_next;
      illegal   <= ill_next;
    end
  end

  `BVM_ASSERT_IMP(a_illegal_halts, clk, rst, rsp_valid && illegal, halted)
  `BVM_ASSERT_IMP(a_in_out_excl, clk, rst, rsp_valid, !(out_valid && in_taken))
  `BVM_ASSERT_IMP(a_out_byte_zero, clk, rst, rsp_valid && !out_valid, out_byte == 8'd0)
  `BVM_ASSERT_IMP(a_stopped_no_write, clk, rst, stopped, !rf_we)
  `BVM_ASSERT_NXT(a_halt_sticky, clk, rst, rsp_valid && rsp_ready && halted, !rsp_valid || halted)

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for byte_vm_instruction_execute_top: directed table, random programs, halt.
// Depends on bvm_pkg and the RTL of byte_vm_instruction_execute_top.
module tb_top;
  import bvm_pkg::*;

  localparam logic [7:0] OP_UNUSED_ZERO = 8'h00;
  localparam logic [7:0] OP_UNUSED_LOW  = 8'h13;
  localparam logic [7:0] OP_UNUSED_HIGH = 8'hFF;

  typedef struct packed {
    logic [15:0] pc;
    logic        ov;
    logic [7:0]  ob;
    logic        it;
    logic        h;
    logic        il;
  } vm_result_t;

  typedef struct {
    logic [7:0] op;
    logic [7:0] opd;
    logic [7:0] ib;
    logic       ae;
    bit         typed;
    vm_result_t res;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [7:0]  req_type;
  logic [7:0]  operand;
  logic [7:0]  in_byte;
  logic        in_at_end;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [15:0] next_pc;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        in_taken;
  logic        halted;
  logic        illegal;

  // architectural state mirrored by the predictor
  logic [7:0]  vm_regs [16] = '{default: 8'h00};
  logic        vm_zero    = 1'b0;
  logic        vm_end     = 1'b0;
  logic [15:0] vm_pc      = 16'h0000;
  logic        vm_stopped = 1'b0;

  vm_result_t  expect_q [$];
  int          sent_count = 0;
  int          rsp_count  = 0;
  int          out_count  = 0;
  int          in_count   = 0;
  int          failures   = 0;
  logic [7:0]  stop_op;

  // notes: JZ jumps while ZERO is clear, JNZ while it is set
  vector_t dir_tbl [$] = '{
    '{OP_INC,  8'h00, 8'h00, 1'b0, 1'b1, '{16'h0002, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_DEC,  8'h01, 8'h00, 1'b0, 1'b1, '{16'h0004, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_MOVC, 8'h80, 8'h00, 1'b0, 1'b0, '0},
    '{OP_OUT,  8'h00, 8'h00, 1'b0, 1'b1, '{16'h0008, 1'b1, 8'h80, 1'b0, 1'b0, 1'b0}},
    '{OP_LSL,  8'h00, 8'hFF, 1'b0, 1'b0, '0},
    '{OP_LSR,  8'h01, 8'h00, 1'b0, 1'b0, '0},
    '{OP_MOV,  8'h12, 8'h00, 1'b0, 1'b0, '0},
    '{OP_ADD,  8'h12, 8'h00, 1'b0, 1'b0, '0},
    '{OP_SUB,  8'h23, 8'h00, 1'b0, 1'b0, '0},
    '{OP_XOR,  8'h1F, 8'h00, 1'b0, 1'b0, '0},
    '{OP_OR,   8'hFE, 8'h00, 1'b0, 1'b0, '0},
    '{OP_IN,   8'h05, 8'hA5, 1'b0, 1'b1, '{16'h0018, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{OP_OUT,  8'h05, 8'h00, 1'b0, 1'b0, '0},
    '{OP_JZ,   8'h08, 8'h00, 1'b0, 1'b0, '0},
    '{OP_JNZ,  8'hFC, 8'h00, 1'b0, 1'b0, '0},
    '{OP_JFE,  8'h04, 8'h00, 1'b0, 1'b0, '0},
    '{OP_JMP,  8'h80, 8'h00, 1'b0, 1'b1, '{16'hFFA6, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_JMP,  8'h7F, 8'h00, 1'b0, 1'b1, '{16'h0025, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_IN,   8'h06, 8'h33, 1'b1, 1'b1, '{16'h0027, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_JFE,  8'h10, 8'h00, 1'b0, 1'b0, '0},
    '{OP_CMPZ, 8'h04, 8'h00, 1'b0, 1'b0, '0},
    '{OP_JNZ,  8'h20, 8'h00, 1'b0, 1'b0, '0},
    '{OP_JZ,   8'h20, 8'h00, 1'b0, 1'b0, '0},
    '{OP_CMPZ, 8'h02, 8'h00, 1'b0, 1'b0, '0},
    '{OP_IN,   8'hF0, 8'h00, 1'b0, 1'b0, '0}
  };

  byte_vm_instruction_execute_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req_type),
    .operand   (operand),
    .in_byte   (in_byte),
    .in_at_end (in_at_end),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .next_pc   (next_pc),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .in_taken  (in_taken),
    .halted    (halted),
    .illegal   (illegal)
  );

  always #5 clk = ~clk;

  function automatic bit quiet_window();
    return sent_count >= 600 && sent_count < 800;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH response %0d: %s", $realtime, rsp_count, what);
    failures++;
  endtask

  task automatic execute_instr(input logic [7:0] op, input logic [7:0] opd,
                               input logic [7:0] ib, input logic ae,
                               output vm_result_t r);
    logic [3:0]  rd;
    logic [3:0]  rs;
    logic [15:0] target;
    logic [15:0] npc;
    rd     = opd[3:0];
    rs     = opd[7:4];
    target = vm_pc + {{8{opd[7]}}, opd};
    npc    = vm_pc + 16'd2;
    r      = '0;
    if (vm_stopped) begin
      r.pc = vm_pc;
      r.h  = 1'b1;
      return;
    end
    case (op)
      OP_INC:  vm_regs[rd] = vm_regs[rd] + 8'd1;
      OP_DEC:  vm_regs[rd] = vm_regs[rd] - 8'd1;
      OP_MOV:  vm_regs[rd] = vm_regs[rs];
      OP_MOVC: vm_regs[0] = opd;
      OP_LSL:  vm_regs[rd] = {vm_regs[rd][6:0], 1'b0};
      OP_LSR:  vm_regs[rd] = {1'b0, vm_regs[rd][7:1]};
      OP_JMP:  npc = target;
      OP_JZ:   if (!vm_zero) npc = target;
      OP_JNZ:  if (vm_zero) npc = target;
      OP_JFE:  if (vm_end) npc = target;
      OP_RET: begin
        vm_stopped = 1'b1;
        npc = vm_pc;
      end
      OP_ADD:  vm_regs[rd] = vm_regs[rd] + vm_regs[rs];
      OP_SUB:  vm_regs[rd] = vm_regs[rd] - vm_regs[rs];
      OP_XOR:  vm_regs[rd] = vm_regs[rd] ^ vm_regs[rs];
      OP_OR:   vm_regs[rd] = vm_regs[rd] | vm_regs[rs];
      OP_IN: begin
        if (ae) begin
          vm_end = 1'b1;
        end else begin
          vm_regs[rd] = ib;
          r.it = 1'b1;
        end
      end
      OP_OUT: begin
        r.ov = 1'b1;
        r.ob = vm_regs[rd];
      end
      OP_CMPZ: if (vm_regs[rd] == 8'h00) vm_zero = 1'b1;
      default: begin
        vm_stopped = 1'b1;
        r.il = 1'b1;
        npc = vm_pc;
      end
    endcase
    vm_pc = npc;
    r.pc  = vm_pc;
    r.h   = vm_stopped;
  endtask

  task automatic send_req(input logic [7:0] op, input logic [7:0] opd, input logic [7:0] ib,
                          input logic ae, input bit typed, input vm_result_t typed_res);
    int         gap;
    vm_result_t pred;
    gap = 0;
    if (!quiet_window()) begin
      while ($urandom_range(0, 99) < 12) gap++;
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= op;
    operand   <= opd;
    in_byte   <= ib;
    in_at_end <= ae;
    do @(posedge clk); while (!req_ready);
    execute_instr(op, opd, ib, ae, pred);
    expect_q.push_back(typed ? typed_res : pred);
    sent_count++;
  endtask

  // response side: random stalls, one long hold-off to back the block up
  initial begin
    int         hold_left;
    bit         hold_done;
    vm_result_t exp_res;
    hold_left = 0;
    hold_done = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (expect_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          exp_res = expect_q.pop_front();
          if (next_pc !== exp_res.pc)
            report_mismatch($sformatf("next_pc %h, expected %h", next_pc, exp_res.pc));
          if (out_valid !== exp_res.ov)
            report_mismatch($sformatf("out_valid %b, expected %b", out_valid, exp_res.ov));
          if (out_byte !== exp_res.ob)
            report_mismatch($sformatf("out_byte %h, expected %h", out_byte, exp_res.ob));
          if (in_taken !== exp_res.it)
            report_mismatch($sformatf("in_taken %b, expected %b", in_taken, exp_res.it));
          if (halted !== exp_res.h)
            report_mismatch($sformatf("halted %b, expected %b", halted, exp_res.h));
          if (illegal !== exp_res.il)
            report_mismatch($sformatf("illegal %b, expected %b", illegal, exp_res.il));
          if (exp_res.ov) out_count++;
          if (exp_res.it) in_count++;
        end
        rsp_count++;
      end
      if (!hold_done && rsp_count == 300) begin
        hold_done = 1;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (quiet_window()) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= 12);
      end
    end
  end

  initial begin
    logic [7:0] op;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_type  <= OP_INC;
    operand   <= 8'h00;
    in_byte   <= 8'h00;
    in_at_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i])
      send_req(dir_tbl[i].op, dir_tbl[i].opd, dir_tbl[i].ib, dir_tbl[i].ae,
               dir_tbl[i].typed, dir_tbl[i].res);

    // running programs: every legal opcode but RET, end of input now and then
    repeat (1000) begin
      do op = 8'($urandom_range(int'(OP_INC), int'(OP_CMPZ))); while (op == OP_RET);
      send_req(op, 8'($urandom), 8'($urandom), ($urandom_range(0, 15) == 0), 1'b0, '0);
    end

    // stop the machine by RET or an unknown opcode, then keep issuing requests
    case ($urandom_range(0, 3))
      0:       stop_op = OP_RET;
      1:       stop_op = OP_UNUSED_ZERO;
      2:       stop_op = OP_UNUSED_HIGH;
      default: stop_op = 8'($urandom_range(int'(OP_UNUSED_LOW), int'(OP_UNUSED_HIGH)));
    endcase
    send_req(stop_op, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
    repeat (30)
      send_req(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
    req_valid <= 1'b0;

    while (expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d instructions (%0d responses checked), %0d OUT bytes, %0d IN reads.",
             sent_count, rsp_count, out_count, in_count);
    $display("Machine stopped by opcode 0x%02h; final pc 0x%04h.", stop_op, vm_pc);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("Timeout: %0d requests sent, %0d responses seen", sent_count, rsp_count);
    $display("Test completed with failures");
    $finish;
  end

endmodule
